[rtl/vfcm_pkg.sv]
// Shared types, constants and neighbor address function of the voxel face-culling mesher.
package vfcm_pkg;

    // Grid geometry and field widths
    localparam int GRID_W     = 16;
    localparam int GRID_H     = 16;
    localparam int CODE_BITS  = 4;
    localparam int COORD_W    = 4;
    localparam int MASK_W     = 16;
    localparam int VCOUNT_W   = 17;
    localparam int RAM_DEPTH  = GRID_W * GRID_H * GRID_W;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    localparam logic [MASK_W-1:0]   SOLID_MASK_RESET = MASK_W'(2);
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX       = {VCOUNT_W{1'b1}};
    localparam logic [VCOUNT_W-1:0] VERTS_PER_FACE   = VCOUNT_W'(4);

    // Probe slots of one cell query: the cell itself, then the six faces
    localparam logic [2:0] PROBE_CENTER = 3'd0;
    localparam logic [2:0] PROBE_LAST   = 3'd6;
    localparam logic [2:0] PROBE_END    = 3'd7;

    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_CELL     = 2'd1,
        ACT_NEW_MESH = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        DIR_ZPOS = 3'd0,
        DIR_XNEG = 3'd1,
        DIR_ZNEG = 3'd2,
        DIR_XPOS = 3'd3,
        DIR_YPOS = 3'd4,
        DIR_YNEG = 3'd5
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 oob;
        logic [ADDR_W-1:0]    addr;
    } loc_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [CODE_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } ram_req_t;

    typedef struct packed {
        logic [COORD_W-1:0]   face_x;
        logic [COORD_W-1:0]   face_y;
        logic [COORD_W-1:0]   face_z;
        logic [2:0]           face_dir;
        logic                 visible;
        logic [VCOUNT_W-1:0]  base_vertex;
        logic                 last;
    } face_t;

    // Locate the voxel of a probe slot: the cell, or its neighbor across a face
    function automatic loc_t nbr_loc(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z,
        input logic [2:0]         probe
    );
        logic [COORD_W:0] nx;
        logic [COORD_W:0] ny;
        logic [COORD_W:0] nz;
        loc_t             loc;
        nx = {1'b0, x};
        ny = {1'b0, y};
        nz = {1'b0, z};
        case (probe)
            3'd1:    nz = nz + 1'b1;
            3'd2:    nx = nx - 1'b1;
            3'd3:    nz = nz - 1'b1;
            3'd4:    nx = nx + 1'b1;
            3'd5:    ny = ny + 1'b1;
            3'd6:    ny = ny - 1'b1;
            default: ;
        endcase
        // Underflow wraps to the top of the range and lands outside the grid
        loc.oob  = (nx >= (COORD_W+1)'(GRID_W)) || (ny >= (COORD_W+1)'(GRID_H)) ||
                   (nz >= (COORD_W+1)'(GRID_W));
        loc.addr = ADDR_W'((ADDR_W'(nx) * ADDR_W'(GRID_H) + ADDR_W'(ny)) * ADDR_W'(GRID_W)
                   + ADDR_W'(nz));
        return loc;
    endfunction

endpackage

[rtl/vfcm_voxel_ram.sv]
// Voxel code memory: one write port, one registered read port with read enable.
module vfcm_voxel_ram (
    input  logic                            clk,
    input  vfcm_pkg::ram_req_t              req,
    output logic [vfcm_pkg::CODE_BITS-1:0]  rdata
);

    logic [vfcm_pkg::CODE_BITS-1:0] mem [vfcm_pkg::RAM_DEPTH];
    logic [vfcm_pkg::CODE_BITS-1:0] rdata_reg;

    // Store a code
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read; hold the data while the read enable is low
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/vfcm_seq.sv]
// Action sequencer: writes voxels, scans a cell and its six neighbors, builds face records.
module vfcm_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  vfcm_pkg::action_t               action,
    input  logic [vfcm_pkg::COORD_W-1:0]    pos_x,
    input  logic [vfcm_pkg::COORD_W-1:0]    pos_y,
    input  logic [vfcm_pkg::COORD_W-1:0]    pos_z,
    input  logic [vfcm_pkg::CODE_BITS-1:0]  block_code,
    input  logic [vfcm_pkg::MASK_W-1:0]     solid_mask,
    input  logic                            out_free,
    output logic                            emit_valid,
    output vfcm_pkg::face_t                 emit_face,
    output vfcm_pkg::ram_req_t              ram_req,
    input  logic [vfcm_pkg::CODE_BITS-1:0]  ram_rdata
);

    vfcm_pkg::state_t                  state_reg, state_next;
    logic [vfcm_pkg::COORD_W-1:0]      x_reg, x_next;
    logic [vfcm_pkg::COORD_W-1:0]      y_reg, y_next;
    logic [vfcm_pkg::COORD_W-1:0]      z_reg, z_next;
    logic [2:0]                        probe_reg, probe_next;
    logic                              eval_valid_reg, eval_valid_next;
    logic [2:0]                        eval_idx_reg, eval_idx_next;
    logic                              eval_oob_reg, eval_oob_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [2:0]                        pend_dir_reg, pend_dir_next;
    logic [vfcm_pkg::VCOUNT_W-1:0]     pend_base_reg, pend_base_next;
    logic [vfcm_pkg::VCOUNT_W-1:0]     vcount_reg, vcount_next;

    vfcm_pkg::loc_t                    probe_loc;
    vfcm_pkg::loc_t                    in_loc;
    logic                              eval_solid;
    logic                              eval_face;
    logic                              stall;
    logic [vfcm_pkg::VCOUNT_W-1:0]     vcount_inc;

    // Locate the current probe and the incoming write target
    assign probe_loc = vfcm_pkg::nbr_loc(x_reg, y_reg, z_reg, probe_reg);
    assign in_loc    = vfcm_pkg::nbr_loc(pos_x, pos_y, pos_z, vfcm_pkg::PROBE_CENTER);

    // Classify the voxel whose code has just come back from memory
    assign eval_solid = !eval_oob_reg && solid_mask[ram_rdata];
    assign eval_face  = eval_valid_reg && (eval_idx_reg != vfcm_pkg::PROBE_CENTER) &&
                        !eval_solid;
    // A new face pushes out the pending one, which needs a free output slot
    assign stall      = eval_face && pend_valid_reg && !out_free;

    // Saturating vertex advance
    assign vcount_inc = (vcount_reg > (vfcm_pkg::VCOUNT_MAX - vfcm_pkg::VERTS_PER_FACE)) ?
                        vfcm_pkg::VCOUNT_MAX : (vcount_reg + vfcm_pkg::VERTS_PER_FACE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vfcm_pkg::ST_IDLE;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            vcount_reg     <= '0;
            probe_reg      <= vfcm_pkg::PROBE_CENTER;
        end
        else
        begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            vcount_reg     <= vcount_next;
            probe_reg      <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        eval_idx_reg  <= eval_idx_next;
        eval_oob_reg  <= eval_oob_next;
        pend_dir_reg  <= pend_dir_next;
        pend_base_reg <= pend_base_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        probe_next      = probe_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        eval_oob_next   = eval_oob_reg;
        pend_valid_next = pend_valid_reg;
        pend_dir_next   = pend_dir_reg;
        pend_base_next  = pend_base_reg;
        vcount_next     = vcount_reg;

        in_ready      = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = in_loc.addr;
        ram_req.wdata = block_code;
        ram_req.re    = 1'b0;
        ram_req.raddr = probe_loc.addr;

        emit_valid            = 1'b0;
        emit_face.face_x      = x_reg;
        emit_face.face_y      = y_reg;
        emit_face.face_z      = z_reg;
        emit_face.face_dir    = pend_dir_reg;
        emit_face.visible     = 1'b1;
        emit_face.base_vertex = pend_base_reg;
        emit_face.last        = 1'b0;

        case (state_reg)
            vfcm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action)
                        vfcm_pkg::ACT_WRITE:
                        begin
                            ram_req.we = !in_loc.oob;
                        end
                        vfcm_pkg::ACT_CELL:
                        begin
                            x_next          = pos_x;
                            y_next          = pos_y;
                            z_next          = pos_z;
                            probe_next      = vfcm_pkg::PROBE_CENTER;
                            eval_valid_next = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = vfcm_pkg::ST_SCAN;
                        end
                        vfcm_pkg::ACT_NEW_MESH:
                        begin
                            vcount_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            vfcm_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    // Issue the next probe read
                    if (probe_reg != vfcm_pkg::PROBE_END)
                    begin
                        ram_req.re      = 1'b1;
                        eval_valid_next = 1'b1;
                        eval_idx_next   = probe_reg;
                        eval_oob_next   = probe_loc.oob;
                        probe_next      = probe_reg + 3'd1;
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end

                    if (eval_valid_reg)
                    begin
                        // Empty cell: no faces, report it at once
                        if ((eval_idx_reg == vfcm_pkg::PROBE_CENTER) && !eval_solid)
                        begin
                            state_next = vfcm_pkg::ST_FINISH;
                        end
                        // Exposed face: release the pending one, keep this one back
                        if (eval_face)
                        begin
                            emit_valid      = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_dir_next   = eval_idx_reg - 3'd1;
                            pend_base_next  = vcount_reg;
                            vcount_next     = vcount_inc;
                        end
                        if (eval_idx_reg == vfcm_pkg::PROBE_LAST)
                        begin
                            state_next = vfcm_pkg::ST_FINISH;
                        end
                    end
                end
            end

            vfcm_pkg::ST_FINISH:
            begin
                // Close the query with the held face, or with an empty record
                emit_face.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    emit_face.face_dir    = vfcm_pkg::DIR_ZPOS;
                    emit_face.visible     = 1'b0;
                    emit_face.base_vertex = vcount_reg;
                end
                if (out_free)
                begin
                    emit_valid      = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = vfcm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vfcm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/voxel_face_cull_mesher.sv]
// Voxel face-culling mesher top level: ports, mask register, output register.
//
// Input stream (s_*): one transaction per action. s_tuser selects the action:
// write a block code, mesh one cell, or start a new mesh (clear the vertex index).
// Output stream (m_*): face records of a cell query, m_tlast on the final one.
// A query on an empty or fully buried cell yields one record with visible low.
// cfg_we/cfg_wdata load the 16-bit solid mask; write it only while idle.
// Write, new-mesh and unused actions give no output.
// A query on a solid cell makes seven reads of the voxel memory (cell plus six
// neighbors) through its single read port, checks the last read, puts out the
// closing record and returns to idle before the next input can be accepted;
// a query on an empty cell ends after its own read.
// The first record does not appear on m_tvalid at acceptance, since each face
// is held back until the next one (or the end of the scan) sets m_tlast.
// Reset clears the vertex index, sets the solid mask to 2 and empties the
// output register; voxel memory contents are undefined until written.
// When the receiver stalls, the scan waits on the held face and s_tready
// stays low until the query's last record is in the output register.
module voxel_face_cull_mesher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pos_x[3:0], pos_y[7:4], pos_z[11:8], block_code[15:12]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // face_x[3:0], face_y[7:4], face_z[11:8], face_dir[14:12],
                                   // base_vertex[31:15]
    output logic        m_tuser,   // visible
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [vfcm_pkg::MASK_W-1:0]    mask_reg;
    logic                           m_valid_reg;
    vfcm_pkg::face_t                m_face_reg;
    logic                           out_free;
    logic                           emit_valid;
    vfcm_pkg::face_t                emit_face;
    vfcm_pkg::ram_req_t             ram_req;
    logic [vfcm_pkg::CODE_BITS-1:0] ram_rdata;

    // Hold the solid mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= vfcm_pkg::SOLID_MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Output register: load a record, drop it once taken
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            m_face_reg <= emit_face;
        end
    end

    vfcm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (vfcm_pkg::action_t'(s_tuser)),
        .pos_x      (s_tdata[3:0]),
        .pos_y      (s_tdata[7:4]),
        .pos_z      (s_tdata[11:8]),
        .block_code (s_tdata[15:12]),
        .solid_mask (mask_reg),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_face  (emit_face),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    vfcm_voxel_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Pack the record onto the output stream
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_face_reg.base_vertex, m_face_reg.face_dir, m_face_reg.face_z,
                       m_face_reg.face_y, m_face_reg.face_x};
    assign m_tuser  = m_face_reg.visible;
    assign m_tlast  = m_face_reg.last;

endmodule

[test/tb_voxel_face_cull_mesher.sv]
// Testbench for the voxel face-culling mesher: stream stimulus, face prediction and checking.
`timescale 1ns / 100ps

module tb_voxel_face_cull_mesher;

    localparam int          CLK_PERIOD     = 12;
    localparam int          RESET_CYCLES   = 5;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          HOLDOFF_CYCLES = 400;
    localparam int          MAX_REPORTS    = 10;
    localparam longint      TIMEOUT_NS     = 2_000_000;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;

    // One action as offered on the input stream
    typedef struct packed {
        logic [1:0]                     act;
        logic [vfcm_pkg::COORD_W-1:0]   x;
        logic [vfcm_pkg::COORD_W-1:0]   y;
        logic [vfcm_pkg::COORD_W-1:0]   z;
        logic [vfcm_pkg::CODE_BITS-1:0] code;
    } voxel_op_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Shadow of the block's state
    logic [vfcm_pkg::CODE_BITS-1:0] voxel_copy [vfcm_pkg::RAM_DEPTH];
    logic [vfcm_pkg::MASK_W-1:0]    solid_mask_copy = vfcm_pkg::SOLID_MASK_RESET;
    logic [vfcm_pkg::VCOUNT_W-1:0]  vertex_index = '0;

    voxel_op_t       op_backlog [$];
    vfcm_pkg::face_t expected_faces [$];
    voxel_op_t       offered_op;
    voxel_op_t       next_op;
    vfcm_pkg::face_t seen_face;
    vfcm_pkg::face_t want_face;

    int   tx_idle_max = 0;
    int   rx_idle_max = 0;
    int   tx_wait = 0;
    int   rx_wait = 0;
    int   rx_draw;
    int   mismatch_count = 0;
    logic rx_hold = 1'b0;
    logic holdoff_go = 1'b0;

    voxel_face_cull_mesher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Step from a voxel to its neighbor across face d
    function automatic void dir_delta(input int d, output int dx, output int dy, output int dz);
        dx = 0;
        dy = 0;
        dz = 0;
        case (d)
            vfcm_pkg::DIR_ZPOS: dz = 1;
            vfcm_pkg::DIR_XNEG: dx = -1;
            vfcm_pkg::DIR_ZNEG: dz = -1;
            vfcm_pkg::DIR_XPOS: dx = 1;
            vfcm_pkg::DIR_YPOS: dy = 1;
            vfcm_pkg::DIR_YNEG: dy = -1;
            default: ;
        endcase
    endfunction

    function automatic int voxel_slot(input int x, input int y, input int z);
        return (x * vfcm_pkg::GRID_H + y) * vfcm_pkg::GRID_W + z;
    endfunction

    // Voxels outside the grid are empty
    function automatic bit solid_at(input int x, input int y, input int z);
        if (x < 0 || x >= vfcm_pkg::GRID_W || y < 0 || y >= vfcm_pkg::GRID_H ||
            z < 0 || z >= vfcm_pkg::GRID_W)
            return 1'b0;
        return solid_mask_copy[voxel_copy[voxel_slot(x, y, z)]];
    endfunction

    function automatic string face_str(input vfcm_pkg::face_t f);
        return $sformatf("x=%0d y=%0d z=%0d dir=%0d visible=%0b base=%0d last=%0b",
                         f.face_x, f.face_y, f.face_z, f.face_dir, f.visible,
                         f.base_vertex, f.last);
    endfunction

    // Update the shadow state and queue the face records one action yields
    task automatic apply_voxel_op(input voxel_op_t op);
        logic [5:0]      open_faces;
        vfcm_pkg::face_t rec;
        int              d;
        int              dx;
        int              dy;
        int              dz;
        open_faces = '0;
        case (op.act)
            vfcm_pkg::ACT_WRITE:
                voxel_copy[voxel_slot(op.x, op.y, op.z)] = op.code;
            vfcm_pkg::ACT_NEW_MESH:
                vertex_index = '0;
            vfcm_pkg::ACT_CELL:
            begin
                if (solid_at(op.x, op.y, op.z))
                begin
                    for (d = 0; d < 6; d++)
                    begin
                        dir_delta(d, dx, dy, dz);
                        open_faces[d] = !solid_at(int'(op.x) + dx, int'(op.y) + dy,
                                                  int'(op.z) + dz);
                    end
                end
                rec.face_x = op.x;
                rec.face_y = op.y;
                rec.face_z = op.z;
                if (open_faces == '0)
                begin
                    // Empty or buried cell: one closing record, no face
                    rec.face_dir    = vfcm_pkg::DIR_ZPOS;
                    rec.visible     = 1'b0;
                    rec.base_vertex = vertex_index;
                    rec.last        = 1'b1;
                    expected_faces  = {expected_faces, rec};
                end
                else
                begin
                    for (d = 0; d < 6; d++)
                    begin
                        if (open_faces[d])
                        begin
                            rec.face_dir    = 3'(d);
                            rec.visible     = 1'b1;
                            rec.base_vertex = vertex_index;
                            rec.last        = ((open_faces >> (d + 1)) == '0);
                            expected_faces  = {expected_faces, rec};
                            // Advance the vertex index, saturating at the top
                            if (vertex_index > vfcm_pkg::VCOUNT_MAX - vfcm_pkg::VERTS_PER_FACE)
                                vertex_index = vfcm_pkg::VCOUNT_MAX;
                            else
                                vertex_index = vertex_index + vfcm_pkg::VERTS_PER_FACE;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Input side: offer queued actions, with a random gap after each one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_wait  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_voxel_op(offered_op);
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait != 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_wait  <= tx_wait - 1;
                end
                else if (op_backlog.size() != 0)
                begin
                    next_op    = op_backlog.pop_front();
                    offered_op <= next_op;
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {next_op.code, next_op.z, next_op.y, next_op.x};
                    s_tuser    <= next_op.act;
                    tx_wait    <= $urandom_range(0, tx_idle_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: check each face transaction, stall at random afterwards
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_face.face_x      = m_tdata[3:0];
                seen_face.face_y      = m_tdata[7:4];
                seen_face.face_z      = m_tdata[11:8];
                seen_face.face_dir    = m_tdata[14:12];
                seen_face.base_vertex = m_tdata[31:15];
                seen_face.visible     = m_tuser;
                seen_face.last        = m_tlast;
                if (expected_faces.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected face record: %s", $realtime,
                                 face_str(seen_face));
                end
                else
                begin
                    want_face = expected_faces.pop_front();
                    if (seen_face !== want_face)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: face record differs\n  expected %s\n  actual   %s",
                                     $realtime, face_str(want_face), face_str(seen_face));
                    end
                end
            end
            if (rx_hold)
                m_tready <= 1'b0;
            else if (m_tvalid && m_tready)
            begin
                rx_draw = $urandom_range(0, rx_idle_max);
                m_tready <= (rx_draw == 0);
                rx_wait  <= (rx_draw == 0) ? 0 : rx_draw - 1;
            end
            else if (rx_wait != 0)
            begin
                m_tready <= 1'b0;
                rx_wait  <= rx_wait - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial
    begin : rx_holdoff
        wait (holdoff_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_op(input logic [1:0] act, input int x, input int y, input int z,
                            input int code);
        voxel_op_t op;
        op.act  = act;
        op.x    = vfcm_pkg::COORD_W'(x);
        op.y    = vfcm_pkg::COORD_W'(y);
        op.z    = vfcm_pkg::COORD_W'(z);
        op.code = vfcm_pkg::CODE_BITS'(code);
        op_backlog = {op_backlog, op};
    endtask

    // Write a cell and its six neighbors
    task automatic queue_cross(input int x, input int y, input int z, input int center,
                               input int ring);
        int d;
        int dx;
        int dy;
        int dz;
        queue_op(vfcm_pkg::ACT_WRITE, x, y, z, center);
        for (d = 0; d < 6; d++)
        begin
            dir_delta(d, dx, dy, dz);
            queue_op(vfcm_pkg::ACT_WRITE, x + dx, y + dy, z + dz, ring);
        end
    endtask

    // Coordinate inside a 3-wide working box at the low or the high grid boundary
    function automatic int box_at(input int extent, input bit high_box, input int offset);
        return high_box ? (extent - 1 - offset) : offset;
    endfunction

    // Fill a working box with air so every probe of its queried cells hits a written voxel
    task automatic queue_fill_box(input bit high_box);
        int i;
        int j;
        int l;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                for (l = 0; l < 3; l++)
                    queue_op(vfcm_pkg::ACT_WRITE, box_at(vfcm_pkg::GRID_W, high_box, i),
                             box_at(vfcm_pkg::GRID_H, high_box, j),
                             box_at(vfcm_pkg::GRID_W, high_box, l), 0);
    endtask

    // Writes land anywhere in a box; queries stay in its two layers next to the boundary
    task automatic queue_random_ops(input int count);
        int k;
        int span;
        int x;
        int y;
        int z;
        int roll;
        bit high_box;
        high_box = 1'b0;
        for (k = 0; k < count; k++)
        begin
            if (k % 8 == 0)
                high_box = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            span = (roll < 40) ? 2 : 1;
            x    = box_at(vfcm_pkg::GRID_W, high_box, $urandom_range(0, span));
            y    = box_at(vfcm_pkg::GRID_H, high_box, $urandom_range(0, span));
            z    = box_at(vfcm_pkg::GRID_W, high_box, $urandom_range(0, span));
            if (roll < 40)
                queue_op(vfcm_pkg::ACT_WRITE, x, y, z, $urandom_range(0, 15));
            else if (roll < 88)
                queue_op(vfcm_pkg::ACT_CELL, x, y, z, $urandom_range(0, 15));
            else if (roll < 94)
                queue_op(vfcm_pkg::ACT_NEW_MESH, x, y, z, $urandom_range(0, 15));
            else
                queue_op(ACT_UNUSED, x, y, z, $urandom_range(0, 15));
        end
    endtask

    // Wait until every action is taken and every face has come back
    task automatic settle;
        do
            @(negedge clk);
        while (op_backlog.size() != 0 || s_tvalid || expected_faces.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_mask(input logic [vfcm_pkg::MASK_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        solid_mask_copy = value;
    endtask

    initial
    begin : stimulus
        int                          k;
        int                          phase;
        logic [vfcm_pkg::MASK_W-1:0] mask_value;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill both working boxes with air
        queue_fill_box(1'b0);
        queue_fill_box(1'b1);
        rx_idle_max = 5;
        settle;
        tx_idle_max = 5;

        // Directed: corners, empty and buried cells, ignored action, new mesh
        queue_op(vfcm_pkg::ACT_CELL, 0, 0, 0, 0);
        queue_op(vfcm_pkg::ACT_WRITE, 0, 0, 0, 1);
        queue_op(vfcm_pkg::ACT_CELL, 0, 0, 0, 0);
        queue_op(vfcm_pkg::ACT_WRITE, 15, 15, 15, 1);
        queue_op(vfcm_pkg::ACT_CELL, 15, 15, 15, 15);
        queue_op(vfcm_pkg::ACT_WRITE, 15, 15, 14, 15);
        queue_op(vfcm_pkg::ACT_CELL, 15, 15, 14, 0);
        queue_op(ACT_UNUSED, 15, 15, 15, 15);
        queue_op(vfcm_pkg::ACT_CELL, 15, 15, 15, 0);
        queue_op(vfcm_pkg::ACT_NEW_MESH, 15, 15, 15, 15);
        queue_op(vfcm_pkg::ACT_CELL, 0, 0, 0, 0);
        queue_cross(1, 1, 1, 1, 1);
        queue_op(vfcm_pkg::ACT_CELL, 1, 1, 1, 0);
        queue_op(vfcm_pkg::ACT_CELL, 1, 1, 0, 0);
        settle;

        // Random phases under several solid masks, one without idling
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       mask_value = '0;
                1:       mask_value = '1;
                3:       mask_value = vfcm_pkg::SOLID_MASK_RESET;
                default: mask_value = vfcm_pkg::MASK_W'($urandom);
            endcase
            tx_idle_max = (phase == 2) ? 0 : 5;
            rx_idle_max = (phase == 2) ? 0 : 5;
            load_mask(mask_value);
            queue_random_ops(32);
            settle;
        end
        tx_idle_max = 5;
        rx_idle_max = 5;

        // Isolated solid cell, queried while the receiver holds off
        load_mask(vfcm_pkg::SOLID_MASK_RESET);
        queue_cross(14, 14, 14, 1, 0);
        settle;
        holdoff_go = 1'b1;
        for (k = 0; k < 12; k++)
            queue_op(vfcm_pkg::ACT_CELL, 14, 14, 14, $urandom_range(0, 15));
        settle;

        // Restart the mesh and query once more
        queue_op(vfcm_pkg::ACT_NEW_MESH, 3, 12, 9, 6);
        queue_op(vfcm_pkg::ACT_CELL, 14, 14, 14, 0);
        settle;

        if (mismatch_count == 0 && expected_faces.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Abort a run that hangs
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/vfcm_pkg.sv
rtl/vfcm_voxel_ram.sv
rtl/vfcm_seq.sv
rtl/voxel_face_cull_mesher.sv
test/tb_voxel_face_cull_mesher.sv
